// File: hw/rtl/triangle_tile_binner_top_defines.svh
// Assertion macros for the triangle tile binner.
`ifndef TRIANGLE_TILE_BINNER_TOP_DEFINES_SVH
`define TRIANGLE_TILE_BINNER_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TTB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("triangle tile binner: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define TTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("triangle tile binner: next-cycle check failed");

`endif

// File: hw/rtl/ttb_pkg.sv
// Shared types, constants and divider step functions for the triangle tile binner.
`timescale 1ns / 1ps
`default_nettype none
package ttb_pkg;

    localparam int TILE_PIXELS   = 16;
    localparam int MAX_DIMENSION = 4096;
    localparam int TILE_SHIFT    = $clog2(TILE_PIXELS);
    localparam int SIZE_W        = 13;
    localparam int PX_W          = $clog2(MAX_DIMENSION);
    localparam int DIV_STEPS     = 32;
    localparam int LANE_DEPTH    = DIV_STEPS + 2;
    localparam int MERGE_DEPTH   = 3;
    localparam int PIPE_DEPTH    = LANE_DEPTH + MERGE_DEPTH;

    localparam logic [1:0] ST_BINNED = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_OFF    = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [31:0]        tri_index;
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_w;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_w;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_w;
    } ttb_in_t;

    typedef struct packed {
        logic [31:0] out_tri_index;
        logic [1:0]  bin_status;
        logic [7:0]  tile_x_first;
        logic [7:0]  tile_x_last;
        logic [7:0]  tile_y_first;
        logic [7:0]  tile_y_last;
    } ttb_out_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [15:0] lo;
        logic        neg;
        logic        ovf;
    } div_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] n;
    } div_res_t;

    typedef struct packed {
        logic               bad;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } lane_res_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] x_first;
        logic [7:0] x_last;
        logic [7:0] y_first;
        logic [7:0] y_last;
    } bin_res_t;

    function automatic div_t div_init(logic [31:0] v, logic [31:0] w);
        logic [31:0] mag;
        div_t        d;
        mag   = v[31] ? (~v + 32'd1) : v;
        d.rem = {16'd0, mag[31:16]};
        d.quo = 32'd0;
        d.lo  = mag[15:0];
        d.neg = v[31];
        d.ovf = ({16'd0, mag[31:16]} >= w);
        return d;
    endfunction

    function automatic div_t div_step(div_t d, logic [31:0] w);
        logic [32:0] t;
        div_t        r;
        t     = {d.rem, d.lo[15]};
        r     = d;
        r.lo  = {d.lo[14:0], 1'b0};
        if (t >= {1'b0, w}) begin
            r.rem = 32'(t - {1'b0, w});
            r.quo = {d.quo[30:0], 1'b1};
        end else begin
            r.rem = t[31:0];
            r.quo = {d.quo[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_res_t div_final(div_t d);
        logic [32:0] m;
        div_res_t    r;
        m = {1'b0, d.quo} + {32'd0, (d.rem != 32'd0)};
        if (d.neg) begin
            r.ovf = d.ovf || (m > 33'h0_8000_0000);
            r.n   = 32'(~m + 33'd1);
        end else begin
            r.ovf = d.ovf || d.quo[31];
            r.n   = d.quo;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ttb_lane.sv
// One vertex lane: pipelined perspective divide of x and y by w.
`timescale 1ns / 1ps
`default_nettype none
module ttb_lane (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [31:0]        in_x,
    input  wire logic [31:0]        in_y,
    input  wire logic [31:0]        in_w,
    output ttb_pkg::lane_res_t      res
);
    import ttb_pkg::*;

    div_t        dx_reg [0:DIV_STEPS];
    div_t        dy_reg [0:DIV_STEPS];
    logic [31:0] w_reg  [0:DIV_STEPS-1];
    logic        wbad_reg [0:DIV_STEPS];
    lane_res_t   res_reg;
    lane_res_t   res_next;
    div_res_t    fx;
    div_res_t    fy;

    always_comb begin
        fx = div_final(dx_reg[DIV_STEPS]);
        fy = div_final(dy_reg[DIV_STEPS]);
        res_next.bad = wbad_reg[DIV_STEPS] || fx.ovf || fy.ovf;
        res_next.nx  = fx.n;
        res_next.ny  = fy.n;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg[0]   <= div_init(in_x, in_w);
            dy_reg[0]   <= div_init(in_y, in_w);
            w_reg[0]    <= in_w;
            wbad_reg[0] <= in_w[31] || (in_w == 32'd0);
            for (int k = 0; k < DIV_STEPS; k++) begin
                dx_reg[k+1]   <= div_step(dx_reg[k], w_reg[k]);
                dy_reg[k+1]   <= div_step(dy_reg[k], w_reg[k]);
                wbad_reg[k+1] <= wbad_reg[k];
                if (k < DIV_STEPS - 1) begin
                    w_reg[k+1] <= w_reg[k];
                end
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// File: hw/rtl/ttb_merge.sv
// Merge stage: bounding box, off-screen test and pixel-to-tile mapping.
`timescale 1ns / 1ps
`default_nettype none
module ttb_merge (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire ttb_pkg::lane_res_t        l0,
    input  wire ttb_pkg::lane_res_t        l1,
    input  wire ttb_pkg::lane_res_t        l2,
    input  wire logic [ttb_pkg::SIZE_W-1:0] size_x,
    input  wire logic [ttb_pkg::SIZE_W-1:0] size_y,
    output ttb_pkg::bin_res_t              res
);
    import ttb_pkg::*;

    localparam logic signed [31:0] NEG_ONE = -32'sd65536;
    localparam logic signed [31:0] POS_ONE = 32'sd65536;

    logic [1:0]         st1_status_reg;
    logic signed [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [1:0]         st1_status_next;
    logic signed [31:0] min_x_next, max_x_next, min_y_next, max_y_next;

    logic [1:0]         st2_status_reg;
    logic signed [46:0] ax_reg, bx_reg, ay_reg, by_reg;
    logic signed [46:0] ax_next, bx_next, ay_next, by_next;

    bin_res_t           res_reg;
    bin_res_t           res_next;

    function automatic logic signed [31:0] smin(logic signed [31:0] a, logic signed [31:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [31:0] smax(logic signed [31:0] a, logic signed [31:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [46:0] scale(logic signed [31:0] n,
                                                 logic [SIZE_W-1:0] sz);
        logic signed [32:0]     s;
        logic signed [SIZE_W:0] z;
        s = {n[31], n} + 33'sd65536;
        z = {1'b0, sz};
        return s * z;
    endfunction

    function automatic logic [7:0] to_tile(logic signed [29:0] p, logic [SIZE_W-1:0] sz);
        logic [PX_W-1:0] px;
        logic signed [29:0] top;
        top = 30'(sz) - 30'sd1;
        if (p < 30'sd0) begin
            px = '0;
        end else if (p > top) begin
            px = PX_W'(top);
        end else begin
            px = PX_W'(p);
        end
        return 8'(px >> TILE_SHIFT);
    endfunction

    always_comb begin
        min_x_next = smin(smin(l0.nx, l1.nx), l2.nx);
        max_x_next = smax(smax(l0.nx, l1.nx), l2.nx);
        min_y_next = smin(smin(l0.ny, l1.ny), l2.ny);
        max_y_next = smax(smax(l0.ny, l1.ny), l2.ny);
        if (l0.bad || l1.bad || l2.bad) begin
            st1_status_next = ST_BAD;
        end else if (max_x_next < NEG_ONE || min_x_next > POS_ONE ||
                     max_y_next < NEG_ONE || min_y_next > POS_ONE) begin
            st1_status_next = ST_OFF;
        end else begin
            st1_status_next = ST_BINNED;
        end
    end

    always_comb begin
        ax_next = scale(min_x_reg, size_x);
        bx_next = scale(max_x_reg, size_x);
        ay_next = scale(min_y_reg, size_y);
        by_next = scale(max_y_reg, size_y);
    end

    always_comb begin
        res_next.status = st2_status_reg;
        if (st2_status_reg == ST_BINNED) begin
            res_next.x_first = to_tile(30'(ax_reg >>> 17), size_x);
            res_next.x_last  = to_tile(30'((bx_reg + 47'sd131071) >>> 17) - 30'sd1, size_x);
            res_next.y_first = to_tile(30'(ay_reg >>> 17), size_y);
            res_next.y_last  = to_tile(30'((by_reg + 47'sd131071) >>> 17) - 30'sd1, size_y);
        end else begin
            res_next.x_first = 8'd0;
            res_next.x_last  = 8'd0;
            res_next.y_first = 8'd0;
            res_next.y_last  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_status_reg <= st1_status_next;
            min_x_reg      <= min_x_next;
            max_x_reg      <= max_x_next;
            min_y_reg      <= min_y_next;
            max_y_reg      <= max_y_next;
            st2_status_reg <= st1_status_reg;
            ax_reg         <= ax_next;
            bx_reg         <= bx_next;
            ay_reg         <= ay_next;
            by_reg         <= by_next;
            res_reg        <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// File: hw/rtl/triangle_tile_binner_top.sv
// Top level of the triangle tile binner: APB registers, three vertex lanes, merge.
// Throughput: one triangle per cycle while results are taken; each lane runs a 32-stage divider pipeline.
// A stalled result word freezes the whole pipeline until it is taken.
// Reset (synchronous, aresetn low): pipeline empties, frame size returns to 1024.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_tile_binner_top_defines.svh"
module triangle_tile_binner_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ttb_pkg::ttb_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ttb_pkg::ttb_out_t      m_data
);
    import ttb_pkg::*;

    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic [SIZE_W-1:0]     size_x, size_y;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [31:0]           idx_reg [0:PIPE_DEPTH-1];
    logic                  en;
    logic                  tiles_zero;
    lane_res_t             r0, r1, r2;
    bin_res_t              bres;

    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] r);
        if (r == '0) begin
            return SIZE_W'(1);
        end else if (r > SIZE_W'(MAX_DIMENSION)) begin
            return SIZE_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-SIZE_W){1'b0}}, height_reg}
                                             : {{(32-SIZE_W){1'b0}}, width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(1024);
            height_reg <= SIZE_W'(1024);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_HEIGHT) begin
                height_reg <= pwdata[SIZE_W-1:0];
            end else begin
                width_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign size_x  = eff_size(width_reg);
    assign size_y  = eff_size(height_reg);
    assign en      = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg[0] <= s_data.tri_index;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                idx_reg[k] <= idx_reg[k-1];
            end
        end
    end

    ttb_lane u_lane0 (
        .aclk (aclk), .en (en),
        .in_x (s_data.v0_x), .in_y (s_data.v0_y), .in_w (s_data.v0_w),
        .res  (r0)
    );

    ttb_lane u_lane1 (
        .aclk (aclk), .en (en),
        .in_x (s_data.v1_x), .in_y (s_data.v1_y), .in_w (s_data.v1_w),
        .res  (r1)
    );

    ttb_lane u_lane2 (
        .aclk (aclk), .en (en),
        .in_x (s_data.v2_x), .in_y (s_data.v2_y), .in_w (s_data.v2_w),
        .res  (r2)
    );

    ttb_merge u_merge (
        .aclk   (aclk),
        .en     (en),
        .l0     (r0),
        .l1     (r1),
        .l2     (r2),
        .size_x (size_x),
        .size_y (size_y),
        .res    (bres)
    );

    always_comb begin
        m_data.out_tri_index = idx_reg[PIPE_DEPTH-1];
        m_data.bin_status    = bres.status;
        m_data.tile_x_first  = bres.x_first;
        m_data.tile_x_last   = bres.x_last;
        m_data.tile_y_first  = bres.y_first;
        m_data.tile_y_last   = bres.y_last;
    end

    assign tiles_zero = (m_data.tile_x_first | m_data.tile_x_last |
                         m_data.tile_y_first | m_data.tile_y_last) == 8'd0;

    `TTB_ASSERT_IMPL(a_reject_zero, m_valid && m_data.bin_status != ST_BINNED, tiles_zero)
    `TTB_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_reg))
    `TTB_ASSERT_NEXT(a_last_stage, vld_reg[PIPE_DEPTH-2] && en, m_valid)

endmodule
`default_nettype wire
